// ===== design/ttk_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-to-keystroke encoder package
// Shared types, key codes and the character-to-key lookup.
// ----------------------------------------------------------------------------
package ttk_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int STEP_W          = 3;

    localparam logic [7:0] USAGE_LSHIFT = 8'd225;
    localparam logic [7:0] USAGE_PERIOD = 8'd55;

    localparam logic [15:0] CHAR_UPPER_A  = 16'h0041;
    localparam logic [15:0] CHAR_UPPER_Z  = 16'h005A;
    localparam logic [15:0] CHAR_LOWER_A  = 16'h0061;
    localparam logic [15:0] CHAR_LOWER_Z  = 16'h007A;
    localparam logic [15:0] CHAR_ONE      = 16'h0031;
    localparam logic [15:0] CHAR_NINE     = 16'h0039;
    localparam logic [15:0] CHAR_CR       = 16'h000D;
    localparam logic [15:0] CHAR_LF       = 16'h000A;
    localparam logic [15:0] CHAR_ELLIPSIS = 16'h2026;
    localparam logic [15:0] CHAR_LDQUOTE  = 16'h201C;
    localparam logic [15:0] CHAR_RDQUOTE  = 16'h201D;
    localparam logic [15:0] CHAR_LSQUOTE  = 16'h2018;
    localparam logic [15:0] CHAR_RSQUOTE  = 16'h2019;
    localparam logic [15:0] CHAR_EN_DASH  = 16'h2013;
    localparam logic [15:0] CHAR_NBSP     = 16'h00A0;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_SHIFT_KEY,
        CMD_ELLIPSIS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] usage;
    } cmd_t;

    typedef struct packed {
        logic       mapped;
        logic       shift;
        logic [7:0] usage;
    } key_entry_t;

    // Maps one code unit to its key; typographic characters fold to ASCII first.
    function automatic key_entry_t lookup_key(input logic [15:0] c);
        key_entry_t  e;
        logic [15:0] f;
        e = '{mapped: 1'b0, shift: 1'b0, usage: 8'd0};
        f = c;
        if (c == CHAR_LDQUOTE || c == CHAR_RDQUOTE) begin
            f = 16'h0022;
        end else if (c == CHAR_LSQUOTE || c == CHAR_RSQUOTE) begin
            f = 16'h0027;
        end else if (c == CHAR_EN_DASH) begin
            f = 16'h002D;
        end else if (c == CHAR_NBSP) begin
            f = 16'h0020;
        end
        if (f >= CHAR_UPPER_A && f <= CHAR_UPPER_Z) begin
            e = '{mapped: 1'b1, shift: 1'b1, usage: 8'(f - CHAR_UPPER_A + 16'd4)};
        end else if (f >= CHAR_LOWER_A && f <= CHAR_LOWER_Z) begin
            e = '{mapped: 1'b1, shift: 1'b0, usage: 8'(f - CHAR_LOWER_A + 16'd4)};
        end else if (f >= CHAR_ONE && f <= CHAR_NINE) begin
            e = '{mapped: 1'b1, shift: 1'b0, usage: 8'(f - CHAR_ONE + 16'd30)};
        end else if (f[15:7] == 9'd0) begin
            unique case (f[6:0])
                7'h08: e = '{1'b1, 1'b0, 8'd42};
                7'h09: e = '{1'b1, 1'b0, 8'd43};
                7'h0A: e = '{1'b1, 1'b0, 8'd40};
                7'h0D: e = '{1'b1, 1'b0, 8'd40};
                7'h20: e = '{1'b1, 1'b0, 8'd44};
                7'h21: e = '{1'b1, 1'b1, 8'd30};
                7'h22: e = '{1'b1, 1'b1, 8'd52};
                7'h23: e = '{1'b1, 1'b1, 8'd32};
                7'h24: e = '{1'b1, 1'b1, 8'd33};
                7'h25: e = '{1'b1, 1'b1, 8'd34};
                7'h26: e = '{1'b1, 1'b1, 8'd36};
                7'h27: e = '{1'b1, 1'b0, 8'd52};
                7'h28: e = '{1'b1, 1'b1, 8'd38};
                7'h29: e = '{1'b1, 1'b1, 8'd39};
                7'h2A: e = '{1'b1, 1'b1, 8'd37};
                7'h2B: e = '{1'b1, 1'b1, 8'd46};
                7'h2C: e = '{1'b1, 1'b0, 8'd54};
                7'h2D: e = '{1'b1, 1'b0, 8'd45};
                7'h2E: e = '{1'b1, 1'b0, 8'd55};
                7'h2F: e = '{1'b1, 1'b0, 8'd56};
                7'h30: e = '{1'b1, 1'b0, 8'd39};
                7'h3A: e = '{1'b1, 1'b1, 8'd51};
                7'h3B: e = '{1'b1, 1'b0, 8'd51};
                7'h3C: e = '{1'b1, 1'b1, 8'd54};
                7'h3D: e = '{1'b1, 1'b0, 8'd46};
                7'h3E: e = '{1'b1, 1'b1, 8'd55};
                7'h3F: e = '{1'b1, 1'b1, 8'd56};
                7'h40: e = '{1'b1, 1'b1, 8'd31};
                7'h5B: e = '{1'b1, 1'b0, 8'd47};
                7'h5C: e = '{1'b1, 1'b0, 8'd49};
                7'h5D: e = '{1'b1, 1'b0, 8'd48};
                7'h5E: e = '{1'b1, 1'b1, 8'd35};
                7'h5F: e = '{1'b1, 1'b1, 8'd45};
                7'h60: e = '{1'b1, 1'b0, 8'd53};
                7'h7B: e = '{1'b1, 1'b1, 8'd47};
                7'h7C: e = '{1'b1, 1'b1, 8'd49};
                7'h7D: e = '{1'b1, 1'b1, 8'd48};
                7'h7E: e = '{1'b1, 1'b1, 8'd53};
                default: e = '{mapped: 1'b0, shift: 1'b0, usage: 8'd0};
            endcase
        end
        return e;
    endfunction

endpackage

// ===== design/text_to_keystroke_encoder.sv =====
// ----------------------------------------------------------------------------
// Text-to-keystroke encoder
// Turns UTF-16 code units into US-layout USB HID keyboard press/release events.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, code_unit) takes one code unit per
// transaction. The output channel (out_valid, out_stall, scan_code,
// key_pressed, last_event) gives one key event per transaction; last_event
// marks the final event of a code unit. Units that map to no key give no
// events, and a line feed right after a carriage return is dropped.
// The front end classifies a code unit in the cycle it is accepted and writes
// a command into a small queue; the back end expands commands into events.
// With the back end idle, the command of an accepted unit passes through the
// queue and then the output register. The output register issues one event
// per cycle while the receiver does not stall; a plain key gives two events,
// a shifted key four and the ellipsis six. Unmapped units give no output.
// The sustained rate is therefore set by the event sequencer in the back end.
// The input stalls only while the command queue is full, so the input side
// keeps running while the receiver stalls until the queue fills up; a stalled
// event holds its value on the output ports.
// Reset clears the carriage-return flag, empties the queue and drops any
// event in flight.
// ----------------------------------------------------------------------------
module text_to_keystroke_encoder
    import ttk_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  scan_code,
    output logic        key_pressed,
    output logic        last_event
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Front end: acceptance, carriage-return tracking and key lookup.
    ttk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_unit  (code_unit),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue decoupling the two ends.
    ttk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: event sequencing into the output register.
    ttk_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .scan_code   (scan_code),
        .key_pressed (key_pressed),
        .last_event  (last_event)
    );

endmodule

// ===== design/ttk_front.sv =====
// ----------------------------------------------------------------------------
// Text-to-keystroke front end
// Accepts code units, tracks carriage returns and queues key commands.
// ----------------------------------------------------------------------------
module ttk_front
    import ttk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] code_unit,
    input  logic        in_valid,
    input  logic        queue_full,
    output logic        in_stall,
    output logic        push,
    output cmd_t        push_cmd
);

    logic       after_cr_reg;
    logic       after_cr_next;
    logic       accept;
    key_entry_t entry;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign entry    = lookup_key(code_unit);

    always_comb
    begin
        after_cr_next = after_cr_reg;
        push          = 1'b0;
        push_cmd      = '{kind: CMD_KEY, usage: entry.usage};
        if (accept)
        begin
            after_cr_next = (code_unit == CHAR_CR);
            // A line feed that follows a carriage return is swallowed.
            if (code_unit == CHAR_ELLIPSIS)
            begin
                push     = 1'b1;
                push_cmd = '{kind: CMD_ELLIPSIS, usage: USAGE_PERIOD};
            end
            else if (!(code_unit == CHAR_LF && after_cr_reg) && entry.mapped)
            begin
                push     = 1'b1;
                push_cmd = '{kind: entry.shift ? CMD_SHIFT_KEY : CMD_KEY,
                             usage: entry.usage};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_cr_reg <= 1'b0;
        end
        else
        begin
            after_cr_reg <= after_cr_next;
        end
    end

endmodule

// ===== design/ttk_queue.sv =====
// ----------------------------------------------------------------------------
// Text-to-keystroke command queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ttk_queue
    import ttk_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/ttk_back.sv =====
// ----------------------------------------------------------------------------
// Text-to-keystroke back end
// Expands each queued command into key events, one event per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ttk_back
    import ttk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] scan_code,
    output logic       key_pressed,
    output logic       last_event
);

    logic              busy_reg, busy_next;
    cmd_t              cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        scan_code_reg, scan_code_next;
    logic              key_pressed_reg, key_pressed_next;
    logic              last_event_reg, last_event_next;

    logic              out_free;
    logic              emit;
    cmd_t              src_cmd;
    logic [STEP_W-1:0] src_step;
    logic [7:0]        ev_code;
    logic              ev_pressed;
    logic              ev_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign src_cmd  = busy_reg ? cmd_reg : head_cmd;
    assign src_step = busy_reg ? step_reg : '0;
    assign emit     = out_free && (busy_reg || head_valid);
    assign pop      = out_free && !busy_reg && head_valid;

    // Event for the current command and step.
    always_comb
    begin
        ev_code    = src_cmd.usage;
        ev_pressed = 1'b0;
        ev_last    = 1'b0;
        unique case (src_cmd.kind)
            CMD_KEY:
            begin
                ev_pressed = (src_step == STEP_W'(0));
                ev_last    = (src_step == STEP_W'(1));
            end
            CMD_SHIFT_KEY:
            begin
                ev_code    = (src_step == STEP_W'(0) || src_step == STEP_W'(3)) ?
                             USAGE_LSHIFT : src_cmd.usage;
                ev_pressed = (src_step == STEP_W'(0) || src_step == STEP_W'(1));
                ev_last    = (src_step == STEP_W'(3));
            end
            CMD_ELLIPSIS:
            begin
                ev_code    = USAGE_PERIOD;
                ev_pressed = !src_step[0];
                ev_last    = (src_step == STEP_W'(5));
            end
            default:
            begin
                ev_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        busy_next        = busy_reg;
        cmd_next         = cmd_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg;
        scan_code_next   = scan_code_reg;
        key_pressed_next = key_pressed_reg;
        last_event_next  = last_event_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            scan_code_next   = ev_code;
            key_pressed_next = ev_pressed;
            last_event_next  = ev_last;
            busy_next        = !ev_last;
            cmd_next         = src_cmd;
            step_next        = src_step + 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        scan_code_reg   <= scan_code_next;
        key_pressed_reg <= key_pressed_next;
        last_event_reg  <= last_event_next;
    end

    assign out_valid   = out_valid_reg;
    assign scan_code   = scan_code_reg;
    assign key_pressed = key_pressed_reg;
    assign last_event  = last_event_reg;

endmodule

// ===== design/ttk_checker.sv =====
// ----------------------------------------------------------------------------
// Text-to-keystroke checker
// Port-level assertions on the input and event streams, bound to the top level.
// ----------------------------------------------------------------------------
module ttk_checker
    import ttk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [15:0] code_unit,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  scan_code,
    input logic        key_pressed,
    input logic        last_event
);

    // A stalled input transaction stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(code_unit))
        else $error("stalled input transaction changed");

    // A stalled event stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scan_code)
            && $stable(key_pressed) && $stable(last_event))
        else $error("stalled output event changed");

    // Every run of events ends on a key release.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_event |-> !key_pressed)
        else $error("last event of a code unit is a press");

    // A left-shift release always closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_code == USAGE_LSHIFT && !key_pressed |-> last_event)
        else $error("left-shift release is not the last event");

    // A taken key press is followed at once by the release of the same key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && key_pressed && scan_code != USAGE_LSHIFT
        |=> out_valid && !key_pressed && scan_code == $past(scan_code))
        else $error("key press not followed by its release");

endmodule

bind text_to_keystroke_encoder ttk_checker u_ttk_checker (.*);

// ===== tb/sv/text_to_keystroke_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text-to-keystroke encoder testbench
// Sends UTF-16 code units through the input channel and checks every key
// event against a behavioral US-layout keystroke predictor. Directed units
// cover the range edges, the typographic folds, the ellipsis and the line
// ending rules. Random text follows, under bursty input and patterned output
// stalls.
// ----------------------------------------------------------------------------
module text_to_keystroke_encoder_tb;
    import ttk_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_UNITS = 85;
    localparam int MAX_REPORTS  = 10;

    // One key event as it leaves the output channel.
    typedef struct packed {
        logic [7:0] scan;
        logic       pressed;
        logic       last;
    } key_event_t;

    // Key of one character on a US layout; a zero usage means no key.
    typedef struct packed {
        logic       shift;
        logic [7:0] usage;
    } us_key_t;

    // How the receiver stalls during one stretch of cycles.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [15:0] code_unit   = 16'h0000;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  scan_code;
    logic        key_pressed;
    logic        last_event;

    // Key events still owed by the encoder, oldest first.
    key_event_t  pending_keystrokes[$];
    // Mirrors the encoder's memory of a carriage return on the previous unit.
    logic        cr_seen        = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;

    stall_mode_t stall_mode       = STALL_NONE;
    int          stall_phase_left = 0;

    text_to_keystroke_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scan_code   (scan_code),
        .key_pressed (key_pressed),
        .last_event  (last_event)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Keystroke predictor
    // ------------------------------------------------------------------------

    // Typographic quotes, the en dash and the no-break space are typed as
    // their plain ASCII counterparts before the key is looked up.
    function automatic us_key_t us_key_of(input logic [15:0] cu);
        logic [15:0] c;
        c = cu;
        if (cu == CHAR_LDQUOTE || cu == CHAR_RDQUOTE) begin
            c = 16'h0022;
        end else if (cu == CHAR_LSQUOTE || cu == CHAR_RSQUOTE) begin
            c = 16'h0027;
        end else if (cu == CHAR_EN_DASH) begin
            c = 16'h002D;
        end else if (cu == CHAR_NBSP) begin
            c = 16'h0020;
        end

        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return '{1'b1, 8'(c - CHAR_UPPER_A + 16'd4)};
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return '{1'b0, 8'(c - CHAR_LOWER_A + 16'd4)};
        end
        if (c >= CHAR_ONE && c <= CHAR_NINE) begin
            return '{1'b0, 8'(c - CHAR_ONE + 16'd30)};
        end
        if (c > 16'h007F) begin
            return '{1'b0, 8'd0};
        end

        case (c[6:0])
            // Keys typed without shift.
            7'h08: return '{1'b0, 8'd42};
            7'h09: return '{1'b0, 8'd43};
            7'h0A: return '{1'b0, 8'd40};
            7'h0D: return '{1'b0, 8'd40};
            7'h20: return '{1'b0, 8'd44};
            7'h27: return '{1'b0, 8'd52};
            7'h2C: return '{1'b0, 8'd54};
            7'h2D: return '{1'b0, 8'd45};
            7'h2E: return '{1'b0, 8'd55};
            7'h2F: return '{1'b0, 8'd56};
            7'h30: return '{1'b0, 8'd39};
            7'h3B: return '{1'b0, 8'd51};
            7'h3D: return '{1'b0, 8'd46};
            7'h5B: return '{1'b0, 8'd47};
            7'h5C: return '{1'b0, 8'd49};
            7'h5D: return '{1'b0, 8'd48};
            7'h60: return '{1'b0, 8'd53};
            // Keys typed with shift held.
            7'h21: return '{1'b1, 8'd30};
            7'h22: return '{1'b1, 8'd52};
            7'h23: return '{1'b1, 8'd32};
            7'h24: return '{1'b1, 8'd33};
            7'h25: return '{1'b1, 8'd34};
            7'h26: return '{1'b1, 8'd36};
            7'h28: return '{1'b1, 8'd38};
            7'h29: return '{1'b1, 8'd39};
            7'h2A: return '{1'b1, 8'd37};
            7'h2B: return '{1'b1, 8'd46};
            7'h3A: return '{1'b1, 8'd51};
            7'h3C: return '{1'b1, 8'd54};
            7'h3E: return '{1'b1, 8'd55};
            7'h3F: return '{1'b1, 8'd56};
            7'h40: return '{1'b1, 8'd31};
            7'h5E: return '{1'b1, 8'd35};
            7'h5F: return '{1'b1, 8'd45};
            7'h7B: return '{1'b1, 8'd47};
            7'h7C: return '{1'b1, 8'd49};
            7'h7D: return '{1'b1, 8'd48};
            7'h7E: return '{1'b1, 8'd53};
            default: return '{1'b0, 8'd0};
        endcase
    endfunction

    // Appends the events that one accepted code unit must produce.
    function automatic void predict_keystrokes(input logic [15:0] cu);
        logic    prev_cr;
        us_key_t key;
        prev_cr = cr_seen;
        // The flag follows every unit, including those that type nothing.
        cr_seen = (cu == CHAR_CR);

        // CR LF types a single Return: the line feed is swallowed.
        if (cu == CHAR_LF && prev_cr) begin
            return;
        end

        // An ellipsis is three unshifted periods; only the final release
        // closes the run.
        if (cu == CHAR_ELLIPSIS) begin
            for (int i = 0; i < 6; i++) begin
                pending_keystrokes.push_back('{USAGE_PERIOD, (i % 2 == 0), (i == 5)});
            end
            return;
        end

        key = us_key_of(cu);
        if (key.usage == 8'd0) begin
            return;
        end

        if (key.shift) begin
            pending_keystrokes.push_back('{USAGE_LSHIFT, 1'b1, 1'b0});
        end
        pending_keystrokes.push_back('{key.usage, 1'b1, 1'b0});
        pending_keystrokes.push_back('{key.usage, 1'b0, !key.shift});
        if (key.shift) begin
            pending_keystrokes.push_back('{USAGE_LSHIFT, 1'b0, 1'b1});
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: prediction on each input transaction, checking on each output
    // transaction. Prediction comes first in the same block, so an event can
    // never be looked for before its unit has been predicted.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        key_event_t want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_keystrokes(code_unit);
            end
            if (out_valid && !out_stall) begin
                if (pending_keystrokes.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("Unexpected event: scan %0d pressed %0b last %0b",
                                 scan_code, key_pressed, last_event);
                    end
                    mismatch_count++;
                end else begin
                    want = pending_keystrokes.pop_front();
                    if (scan_code !== want.scan || key_pressed !== want.pressed ||
                        last_event !== want.last) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display({"Mismatch: expected scan %0d pressed %0b last %0b,",
                                      " got scan %0d pressed %0b last %0b"},
                                     want.scan, want.pressed, want.last,
                                     scan_code, key_pressed, last_event);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // The watchdog stops a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The receiver switches at random between stall patterns, so stretches
    // with no stall at all alternate with heavy back-pressure.
    always @(negedge clk) begin
        if (stall_phase_left == 0) begin
            stall_mode       = stall_mode_t'($urandom_range(0, 3));
            stall_phase_left = $urandom_range(16, 96);
        end else begin
            stall_phase_left--;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (stall_phase_left % 8 < 3);
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Presents one code unit and holds it until the encoder takes it. Between
    // bursts of random length the input goes idle for a random gap; valid is
    // only ever written once per falling edge.
    task automatic send_unit(input logic [15:0] cu);
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        code_unit <= cu;
        do begin
            @(posedge clk);
        end while (in_stall);

        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid  <= 1'b0;
                code_unit <= 16'($urandom());
            end
        end
    endtask

    // Both ends of the code unit range, DEL, and the edges of the letter
    // and digit runs.
    task automatic test_range_edges;
        send_unit(16'h0000);
        send_unit(16'hFFFF);
        send_unit(16'h007F);
        send_unit(CHAR_LOWER_A);
        send_unit(CHAR_UPPER_Z);
        send_unit(16'h0030);
        send_unit(CHAR_NINE);
    endtask

    // Every typographic character that folds to ASCII, and the ellipsis.
    task automatic test_typographic_folds;
        send_unit(CHAR_LDQUOTE);
        send_unit(CHAR_RDQUOTE);
        send_unit(CHAR_LSQUOTE);
        send_unit(CHAR_RSQUOTE);
        send_unit(CHAR_EN_DASH);
        send_unit(CHAR_NBSP);
        send_unit(CHAR_ELLIPSIS);
    endtask

    // Line feed after carriage return is dropped; a lone line feed, a
    // repeated carriage return and a unit between CR and LF all clear or
    // keep the flag as they should. Backspace and tab close the set.
    task automatic test_line_endings;
        send_unit(CHAR_CR);
        send_unit(CHAR_LF);
        send_unit(CHAR_LF);
        send_unit(CHAR_CR);
        send_unit(CHAR_CR);
        send_unit(CHAR_LF);
        send_unit(CHAR_CR);
        send_unit(16'hD800);
        send_unit(CHAR_LF);
        send_unit(16'h0008);
        send_unit(16'h0009);
    endtask

    // Mostly typeable text with CR LF line breaks and folded characters,
    // mixed with control codes, Latin-1 units and arbitrary 16-bit noise.
    task automatic test_random_text;
        logic [15:0] folded[7];
        int          sent;
        int          kind;
        folded = '{CHAR_LDQUOTE, CHAR_RDQUOTE, CHAR_LSQUOTE, CHAR_RSQUOTE,
                   CHAR_EN_DASH, CHAR_NBSP, CHAR_ELLIPSIS};
        sent = 0;
        while (sent < RANDOM_UNITS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: send_unit(16'($urandom_range(16'h0020, 16'h007E)));
                4: begin
                    send_unit(CHAR_CR);
                    send_unit(CHAR_LF);
                    sent++;
                end
                5: send_unit(16'($urandom_range(16'h0000, 16'h001F)));
                6: send_unit(folded[$urandom_range(0, 6)]);
                9: send_unit(16'($urandom_range(16'h007F, 16'h00FF)));
                default: send_unit(16'($urandom()));
            endcase
            sent++;
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_range_edges();
        test_typographic_folds();
        test_line_endings();
        test_random_text();

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain what is still owed, then give the encoder time to show any
        // stray event left in its queue.
        while (pending_keystrokes.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_keystrokes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ttk_pkg.sv
design/ttk_front.sv
design/ttk_queue.sv
design/ttk_back.sv
design/text_to_keystroke_encoder.sv
design/ttk_checker.sv
tb/sv/text_to_keystroke_encoder_tb.sv
